// ===== design/bop_pkg.sv =====
// Shared types and constants for the box overlap and penetration pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bop_pkg;

    // Fixed field widths of the beat
    localparam int HALF_BITS = 22;
    localparam int PEN_BITS  = 23;
    localparam int SQ_BITS   = 2 * HALF_BITS;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int AXIS_BITS = 2;

    // Normal axis codes
    localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

    // Object kinds carried on the op field
    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    // Load enables for the three per-axis register stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Per-axis result handed to the final stage
    typedef struct packed {
        logic [PEN_BITS-1:0] ov;      // clamped overlap of A with B's bounding box
        logic [SQ_BITS-1:0]  sq;      // squared clamped distance (sphere)
        logic                far;     // sphere centre beyond radius on this axis
        logic                box_ok;  // closed intervals overlap (box)
        logic                cgt;     // A centre above B centre
    } axis_res_t;

endpackage

// ===== design/bop_axis.sv =====
// One axis of the overlap pipeline: bounds, interval tests, clamped distance,
// square and overlap over three register stages. Depends on bop_pkg.
`timescale 1ns / 1ps

module bop_axis
    import bop_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                       aclk,
    input  stage_en_t                  en,
    input  logic [COORD_BITS-1:0]      a_center,
    input  logic [HALF_BITS-1:0]       a_half,
    input  logic [COORD_BITS-1:0]      b_center,
    input  logic [HALF_BITS-1:0]       b_half,
    output axis_res_t                  res
);

    localparam int W = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 2;

    logic signed [W-1:0] ac, bc, ah, bh_ext;

    // stage 1 registers
    logic signed [W-1:0]  amin_reg, amax_reg, bmin_reg, bmax_reg, bc1_reg;
    logic [HALF_BITS-1:0] bh1_reg;
    logic                 cgt1_reg;

    // stage 2 registers
    logic signed [W-1:0]  d_reg, lo_reg, hi_reg;
    logic [HALF_BITS-1:0] bh2_reg;
    logic                 box_ok_reg, cgt2_reg;

    // stage 3 register
    axis_res_t res_reg;

    logic signed [W-1:0] d_next, lo_next, hi_next, ov_full, bh2_ext;
    logic                box_ok_next;

    // Sign-extend centres, zero-extend half sizes
    assign ac     = $signed({{(W-COORD_BITS){a_center[COORD_BITS-1]}}, a_center});
    assign bc     = $signed({{(W-COORD_BITS){b_center[COORD_BITS-1]}}, b_center});
    assign ah     = $signed({{(W-HALF_BITS){1'b0}}, a_half});
    assign bh_ext = $signed({{(W-HALF_BITS){1'b0}}, b_half});

    // Stage 1: interval bounds and centre order
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            amin_reg <= ac - ah;
            amax_reg <= ac + ah;
            bmin_reg <= bc - bh_ext;
            bmax_reg <= bc + bh_ext;
            bc1_reg  <= bc;
            bh1_reg  <= b_half;
            cgt1_reg <= (ac > bc);
        end
    end

    // Stage 2: interval test, clamped distance, overlap limits
    always_comb begin
        box_ok_next = !((amin_reg > bmax_reg) || (amax_reg < bmin_reg));
        if (bc1_reg < amin_reg) begin
            d_next = amin_reg - bc1_reg;
        end else if (bc1_reg > amax_reg) begin
            d_next = bc1_reg - amax_reg;
        end else begin
            d_next = '0;
        end
        lo_next = (amin_reg > bmin_reg) ? amin_reg : bmin_reg;
        hi_next = (amax_reg < bmax_reg) ? amax_reg : bmax_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            d_reg      <= d_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            bh2_reg    <= bh1_reg;
            box_ok_reg <= box_ok_next;
            cgt2_reg   <= cgt1_reg;
        end
    end

    // Stage 3: radius check, square, clamped overlap
    assign bh2_ext = $signed({{(W-HALF_BITS){1'b0}}, bh2_reg});
    assign ov_full = hi_reg - lo_reg;

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            res_reg.far    <= (d_reg > bh2_ext);
            res_reg.sq     <= SQ_BITS'(d_reg[HALF_BITS-1:0]) * SQ_BITS'(d_reg[HALF_BITS-1:0]);
            res_reg.ov     <= ov_full[W-1] ? '0 : ov_full[PEN_BITS-1:0];
            res_reg.box_ok <= box_ok_reg;
            res_reg.cgt    <= cgt2_reg;
        end
    end

    assign res = res_reg;

endmodule

// ===== design/bop_resolve.sv =====
// Final stage: hit decision for box or sphere and least-overlap axis
// selection into the output register. Depends on bop_pkg.
`timescale 1ns / 1ps

module bop_resolve
    import bop_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic                  op,
    input  logic [SQ_BITS-1:0]    rsq,
    input  axis_res_t             res_x,
    input  axis_res_t             res_y,
    input  axis_res_t             res_z,
    output logic                  hit,
    output logic [AXIS_BITS-1:0]  normal_axis,
    output logic                  normal_negative,
    output logic [PEN_BITS-1:0]   penetration
);

    logic [SUM_BITS-1:0]  sum;
    logic                 hit_next, neg_next;
    logic [AXIS_BITS-1:0] axis_next;
    logic [PEN_BITS-1:0]  best;

    logic                 hit_reg, neg_reg;
    logic [AXIS_BITS-1:0] axis_reg;
    logic [PEN_BITS-1:0]  pen_reg;

    assign sum = {2'b00, res_x.sq} + {2'b00, res_y.sq} + {2'b00, res_z.sq};

    // Decide hit, then pick the least overlap; ties keep the earlier axis
    always_comb begin
        if (op == OP_SPHERE) begin
            hit_next = !(res_x.far || res_y.far || res_z.far)
                       && (sum <= {2'b00, rsq});
        end else begin
            hit_next = res_x.box_ok && res_y.box_ok && res_z.box_ok;
        end

        axis_next = AXIS_X;
        best      = res_x.ov;
        neg_next  = res_x.cgt;
        if (best > res_y.ov) begin
            axis_next = AXIS_Y;
            best      = res_y.ov;
            neg_next  = res_y.cgt;
        end
        if (best > res_z.ov) begin
            axis_next = AXIS_Z;
            best      = res_z.ov;
            neg_next  = res_z.cgt;
        end
    end

    // Load the output register; a miss reports all zeros
    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg  <= hit_next;
            axis_reg <= hit_next ? axis_next : AXIS_X;
            neg_reg  <= hit_next && neg_next;
            pen_reg  <= hit_next ? best : '0;
        end
    end

    assign hit             = hit_reg;
    assign normal_axis     = axis_reg;
    assign normal_negative = neg_reg;
    assign penetration     = pen_reg;

endmodule

// ===== design/box_overlap_penetration.sv =====
// Box versus box or sphere collision test with least-penetration axis.
// Top level: stage valids, stall control, radius square. Depends on bop_pkg,
// bop_axis and bop_resolve.
//
// Usage:
//   Input channel s_*: one object pair per beat; s_op selects B as a box or
//   a sphere (radius on s_b_size_x, s_b_size_yz ignored).
//   Result channel m_*: one result beat per input beat, in order.
//   Pipeline: an accepted beat passes through v1, v2 and v3 into the output
//   register, where m_valid rises, if no stall intervenes.
//   Throughput: one beat per cycle while m_ready is high, with four register
//   stages (bounds, interval and distance, square and overlap, decision into
//   the output register), each with its own valid bit.
//   Reset: aresetn low empties every stage and drops m_valid; s_ready is
//   then high, as every stage is empty.
//   Stall: while m_ready is low the output beat holds; earlier stages keep
//   filling empty slots, and s_ready falls only when all four stages are
//   occupied. Nothing is lost or repeated.
`timescale 1ns / 1ps

module box_overlap_penetration
    import bop_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic [COORD_BITS-1:0]     s_a_center_x,
    input  logic [COORD_BITS-1:0]     s_a_center_y,
    input  logic [COORD_BITS-1:0]     s_a_center_z,
    input  logic [HALF_BITS-1:0]      s_a_half_x,
    input  logic [HALF_BITS-1:0]      s_a_half_y,
    input  logic [HALF_BITS-1:0]      s_a_half_z,
    input  logic [COORD_BITS-1:0]     s_b_center_x,
    input  logic [COORD_BITS-1:0]     s_b_center_y,
    input  logic [COORD_BITS-1:0]     s_b_center_z,
    input  logic [HALF_BITS-1:0]      s_b_size_x,
    input  logic [2*HALF_BITS-1:0]    s_b_size_yz,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit,
    output logic [AXIS_BITS-1:0]      m_normal_axis,
    output logic                      m_normal_negative,
    output logic [PEN_BITS-1:0]       m_penetration
);

    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic ld1, ld2, ld3, ld4;
    stage_en_t en;

    logic [HALF_BITS-1:0] b_half_y, b_half_z;
    logic                 op1_reg, op2_reg, op3_reg;
    logic [HALF_BITS-1:0] r1_reg, r2_reg;
    logic [SQ_BITS-1:0]   rsq_reg;

    axis_res_t res_x, res_y, res_z;

    // A stage loads when it is empty or its contents move on
    assign ld4 = !m_valid_reg || m_ready;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign en.s1 = ld1;
    assign en.s2 = ld2;
    assign en.s3 = ld3;

    assign s_ready = ld1;
    assign m_valid = m_valid_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg      <= s_valid;
            if (ld2) v2_reg      <= v1_reg;
            if (ld3) v3_reg      <= v2_reg;
            if (ld4) m_valid_reg <= v3_reg;
        end
    end

    // A sphere uses its radius as the half size on every axis
    assign b_half_y = (s_op == OP_SPHERE) ? s_b_size_x : s_b_size_yz[HALF_BITS-1:0];
    assign b_half_z = (s_op == OP_SPHERE) ? s_b_size_x
                                          : s_b_size_yz[2*HALF_BITS-1:HALF_BITS];

    // Carry op and radius alongside the axis stages; square the radius
    always_ff @(posedge aclk) begin
        if (ld1) begin
            op1_reg <= s_op;
            r1_reg  <= s_b_size_x;
        end
        if (ld2) begin
            op2_reg <= op1_reg;
            r2_reg  <= r1_reg;
        end
        if (ld3) begin
            op3_reg <= op2_reg;
            rsq_reg <= SQ_BITS'(r2_reg) * SQ_BITS'(r2_reg);
        end
    end

    bop_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .aclk     (aclk),
        .en       (en),
        .a_center (s_a_center_x),
        .a_half   (s_a_half_x),
        .b_center (s_b_center_x),
        .b_half   (s_b_size_x),
        .res      (res_x)
    );

    bop_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .aclk     (aclk),
        .en       (en),
        .a_center (s_a_center_y),
        .a_half   (s_a_half_y),
        .b_center (s_b_center_y),
        .b_half   (b_half_y),
        .res      (res_y)
    );

    bop_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
        .aclk     (aclk),
        .en       (en),
        .a_center (s_a_center_z),
        .a_half   (s_a_half_z),
        .b_center (s_b_center_z),
        .b_half   (b_half_z),
        .res      (res_z)
    );

    bop_resolve u_resolve (
        .aclk            (aclk),
        .en              (ld4),
        .op              (op3_reg),
        .rsq             (rsq_reg),
        .res_x           (res_x),
        .res_y           (res_y),
        .res_z           (res_z),
        .hit             (m_hit),
        .normal_axis     (m_normal_axis),
        .normal_negative (m_normal_negative),
        .penetration     (m_penetration)
    );

endmodule

// ===== design/bop_checker.sv =====
// Port-level checks on the result channel of box_overlap_penetration.
// Depends on bop_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module bop_checker
    import bop_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_hit,
    input logic [AXIS_BITS-1:0]  m_normal_axis,
    input logic                  m_normal_negative,
    input logic [PEN_BITS-1:0]   m_penetration
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result beat stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // A miss reports all zeros
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_normal_axis == AXIS_X) && !m_normal_negative
                              && (m_penetration == '0))
        else $error("miss beat carries non-zero fields");

    // Only x, y or z may be reported
    a_axis_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_axis == AXIS_X) || (m_normal_axis == AXIS_Y)
                    || (m_normal_axis == AXIS_Z))
        else $error("normal axis code out of range");

endmodule

bind box_overlap_penetration bop_checker u_bop_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_hit             (m_hit),
    .m_normal_axis     (m_normal_axis),
    .m_normal_negative (m_normal_negative),
    .m_penetration     (m_penetration)
);
